// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the LED pattern tick generator.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication check on the rising clock edge, off while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);
// Check of a consequence in the cycle after its cause.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/lptg_pkg.sv =====
// Package of the LED pattern tick generator: pattern and command codes,
// LED count and the derived LED mask. Depends on nothing.
`timescale 1ns / 1ps

package lptg_pkg;

	localparam int NUM_LEDS = 8;

	// Mask of the LEDs that exist among the eight represented bits.
	localparam logic [7:0] LED_MASK = (NUM_LEDS >= 8) ? 8'hFF :
		8'((16'd1 << NUM_LEDS) - 16'd1);

	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_SELECT = 1'b1;

	localparam logic [2:0] PAT_SOLID     = 3'd0;
	localparam logic [2:0] PAT_FLASH     = 3'd1;
	localparam logic [2:0] PAT_BEACON    = 3'd2;
	localparam logic [2:0] PAT_BREATHE   = 3'd3;
	localparam logic [2:0] PAT_ALTERNATE = 3'd4;

	localparam logic [0:0] REG_LEFT_MASK  = 1'b0;
	localparam logic [0:0] REG_RIGHT_MASK = 1'b1;

endpackage

// ===== rtl/led_pattern_tick_generator.sv =====
// Top level of the LED pattern tick generator: input register, pattern state,
// update logic and result register. Depends on lptg_pkg and assert_macros.svh.
//
//   channel   | direction | handshake                  | contents
//   s_axis    | in        | s_axis_tvalid/tready       | tuser command, tdata pattern_code
//   m_axis    | out       | m_axis_tvalid/tready       | tuser refresh, tdata scale/mask/phase
//   cfg       | in        | cfg_we, no back-pressure   | side masks by index
//
// Each request passes from acceptance through the input register and then the
// result register; a new request is taken every cycle while the output does not stall.
// A single update stage lies between the two registers.
// Reset clears the valid flags and loads the pattern state with its reset
// values; the side masks reset to 15 and 240.
// A stall at the output holds the result register, and the input register
// then holds one more request before s_axis_tready drops.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module led_pattern_tick_generator
	import lptg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [2:0] pattern_code, [7:3] zero
	input  logic        s_axis_tuser,  // [0] command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [7:0] brightness, [15:8] shine_mask, [23:16] phase
	output logic        m_axis_tuser,  // [0] refresh
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_wdata
);

	// Side masks written through the configuration port.
	logic [7:0] left_mask_q;
	logic [7:0] right_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_mask_q  <= 8'd15;
			right_mask_q <= 8'd240;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT_MASK:  left_mask_q  <= cfg_wdata;
				REG_RIGHT_MASK: right_mask_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register stage. The request is held here until the update stage
	// can move its result into the output register.
	logic       valid_s1;
	logic       cmd_s1;
	logic [2:0] code_s1;
	logic       advance;

	// The result register may be loaded when it is empty or being drained.
	assign advance       = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= s_axis_tuser;
			code_s1 <= s_axis_tdata[2:0];
		end
	end

	// Pattern state, updated once for every request that leaves the input
	// register.
	logic [7:0] phase_q;
	logic [2:0] pattern_q;
	logic [7:0] scale_q;
	logic [7:0] shine_q;
	logic       pending_q;

	logic [7:0] phase_nxt;
	logic [2:0] pattern_nxt;
	logic [7:0] scale_nxt;
	logic [7:0] shine_nxt;
	logic       pending_nxt;
	logic       refresh_nxt;

	always_comb begin
		logic [3:0] beacon_q;
		logic [6:0] breathe_m;
		logic [3:0] ramp;
		beacon_q    = 4'd0;
		breathe_m   = 7'd0;
		ramp        = 4'd0;
		phase_nxt   = phase_q;
		pattern_nxt = pattern_q;
		scale_nxt   = scale_q;
		shine_nxt   = shine_q;
		pending_nxt = pending_q;
		refresh_nxt = 1'b0;
		if (cmd_s1 == CMD_TICK) begin
			phase_nxt = phase_q + 8'd1;
			beacon_q  = phase_nxt[5:2];
			breathe_m = phase_nxt[6:0];
			case (pattern_q)
				PAT_SOLID: begin
					if (scale_q != 8'hFF) begin
						scale_nxt   = 8'hFF;
						pending_nxt = 1'b1;
					end
				end
				PAT_FLASH: begin
					if (phase_nxt[1:0] == 2'd0) begin
						scale_nxt   = phase_nxt[2] ? 8'h00 : 8'hFF;
						pending_nxt = 1'b1;
					end
				end
				PAT_BEACON: begin
					if (beacon_q == 4'd1 || beacon_q == 4'd4) begin
						scale_nxt   = 8'hFF;
						pending_nxt = 1'b1;
					end else if (beacon_q == 4'd2 || beacon_q == 4'd5) begin
						scale_nxt   = 8'h00;
						pending_nxt = 1'b1;
					end
				end
				PAT_BREATHE: begin
					// Ramp up over the first sixteen ticks, down over the next.
					if (breathe_m <= 7'd31) begin
						ramp        = breathe_m[4] ? ~breathe_m[3:0] : breathe_m[3:0];
						scale_nxt   = {ramp, 4'd0};
						pending_nxt = 1'b1;
					end
				end
				PAT_ALTERNATE: begin
					if (phase_nxt[3:0] == 4'd0) begin
						shine_nxt   = (phase_nxt[4] ? right_mask_q : left_mask_q) & LED_MASK;
						pending_nxt = 1'b1;
					end
				end
				default: ;
			endcase
			if (pending_nxt) begin
				refresh_nxt = 1'b1;
				pending_nxt = 1'b0;
			end
		end else if (code_s1 <= PAT_ALTERNATE && code_s1 != pattern_q) begin
			// A new pattern restarts from a full-scale, all-on state.
			pattern_nxt = code_s1;
			pending_nxt = 1'b1;
			phase_nxt   = 8'hFF;
			scale_nxt   = 8'hFF;
			shine_nxt   = LED_MASK;
		end
	end

	logic load;
	assign load = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 8'hFF;
			pattern_q <= PAT_SOLID;
			scale_q   <= 8'hFF;
			shine_q   <= LED_MASK;
			pending_q <= 1'b1;
		end else if (load) begin
			phase_q   <= phase_nxt;
			pattern_q <= pattern_nxt;
			scale_q   <= scale_nxt;
			shine_q   <= shine_nxt;
			pending_q <= pending_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (advance) begin
			m_axis_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_axis_tdata <= {phase_nxt, shine_nxt, scale_nxt};
			m_axis_tuser <= refresh_nxt;
		end
	end

	`ASSERT_NEXT(a_select_no_refresh, clk, arst_n, load && cmd_s1 == CMD_SELECT, !m_axis_tuser, "selection result carries refresh")
	`ASSERT_NEXT(a_tick_clears_pending, clk, arst_n, load && cmd_s1 == CMD_TICK, !pending_q, "pending change survived a tick")
	`ASSERT_IMPLY(a_mask_in_range, clk, arst_n, m_axis_tvalid, (m_axis_tdata[15:8] & ~LED_MASK) == 8'd0, "shine mask lights a missing LED")
	`ASSERT_NEXT(a_s1_held_on_stall, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(code_s1) && $stable(cmd_s1), "input register lost a request")

endmodule

// ===== tb/sv/tb_led_pattern_tick_generator.sv =====
// Self-checking testbench for led_pattern_tick_generator: directed and random
// tick and pattern requests, checked against a predictor of the pattern state.
// Depends on lptg_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_led_pattern_tick_generator;
	import lptg_pkg::*;

	// A quiet stretch is at most a sender gap, a receiver stall, the hold-off
	// before a pressure request and the short idle wait around a register
	// write. The limit is taken many times over such a stretch.
	localparam int QUIET_LIMIT = 2000;
	localparam logic [7:0] FULL_SCALE = 8'hFF;

	// One request as the sender sees it. A request marked hold_for_drain is
	// not offered until every result already owed has come back.
	typedef struct packed {
		logic       command;
		logic [2:0] code;
		logic       hold_for_drain;
	} lamp_request_t;

	// One result: what the strip should show after a request.
	typedef struct packed {
		logic [7:0] brightness;
		logic [7:0] shine;
		logic       refresh;
		logic [7:0] phase;
	} lamp_view_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [2:0] pattern_code, [7:3] zero
	logic        s_axis_tuser = 1'b0;    // [0] command
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;           // [7:0] brightness, [15:8] shine_mask, [23:16] phase
	logic        m_axis_tuser;           // [0] refresh
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = REG_LEFT_MASK;
	logic [7:0]  cfg_wdata = 8'h00;

	led_pattern_tick_generator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predicted state of the block, with its own copy of the side masks.
	logic [7:0] model_phase = 8'hFF;
	logic [2:0] model_pattern = PAT_SOLID;
	logic [7:0] model_scale = FULL_SCALE;
	logic [7:0] model_shine = LED_MASK;
	logic       model_change_due = 1'b1;
	logic [7:0] model_left = 8'd15;
	logic [7:0] model_right = 8'd240;

	lamp_request_t queued_requests[$];
	lamp_view_t    owed_views[$];

	int  mismatch_count = 0;
	int  quiet_cycles = 0;
	int  send_wait = 0;
	int  stall_wait = 0;
	bit  req_taken = 1'b0;
	bit  res_taken = 1'b0;
	bit  sender_idles = 1'b1;
	bit  receiver_idles = 1'b1;
	lamp_request_t next_request;
	lamp_view_t    owed;

	// Applies one request to the predicted state and returns the view that the
	// block must produce for it.
	function automatic lamp_view_t advance_pattern(input logic command, input logic [2:0] code);
		lamp_view_t view;
		logic [3:0] quarter;
		logic [6:0] ramp;
		logic       refresh;
		refresh = 1'b0;
		if (command == CMD_TICK) begin
			model_phase = model_phase + 8'd1;
			case (model_pattern)
				PAT_SOLID: begin
					if (model_scale != FULL_SCALE) begin
						model_scale = FULL_SCALE;
						model_change_due = 1'b1;
					end
				end
				PAT_FLASH: begin
					// The scale flips on every fourth tick, dark while phase bit 2 is set.
					if (model_phase[1:0] == 2'd0) begin
						model_scale = model_phase[2] ? 8'h00 : FULL_SCALE;
						model_change_due = 1'b1;
					end
				end
				PAT_BEACON: begin
					// Two short blinks at the start of each 64-tick period.
					quarter = model_phase[5:2];
					if (quarter == 4'd1 || quarter == 4'd4) begin
						model_scale = FULL_SCALE;
						model_change_due = 1'b1;
					end else if (quarter == 4'd2 || quarter == 4'd5) begin
						model_scale = 8'h00;
						model_change_due = 1'b1;
					end
				end
				PAT_BREATHE: begin
					// Ramp up and back down over the first 32 ticks of 128.
					ramp = model_phase[6:0];
					if (ramp <= 7'd31) begin
						if (ramp > 7'd15)
							ramp = 7'd31 - ramp;
						model_scale = {ramp[3:0], 4'b0000};
						model_change_due = 1'b1;
					end
				end
				PAT_ALTERNATE: begin
					if (model_phase[3:0] == 4'd0) begin
						model_shine = (model_phase[4] ? model_right : model_left) & LED_MASK;
						model_change_due = 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (model_change_due) begin
				refresh = 1'b1;
				model_change_due = 1'b0;
			end
		end else if (code <= PAT_ALTERNATE && code != model_pattern) begin
			// A real change of pattern restarts it from a lit, full-scale strip.
			model_pattern = code;
			model_change_due = 1'b1;
			model_phase = 8'hFF;
			model_scale = FULL_SCALE;
			model_shine = LED_MASK;
		end
		view.brightness = model_scale;
		view.shine = model_shine;
		view.refresh = refresh;
		view.phase = model_phase;
		return view;
	endfunction

	// At least half of the draws in an idling stretch give no wait, so back-to-back
	// transfers still occur there.
	function automatic int draw_wait(input bit idles);
		if (!idles || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, 15);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		$display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	task automatic queue_request(input logic command, input logic [2:0] code, input logic hold);
		lamp_request_t req;
		req.command = command;
		req.code = code;
		req.hold_for_drain = hold;
		queued_requests.push_back(req);
	endtask

	// Mostly well-formed runs: select a pattern, then a run of ticks long enough
	// to walk through its cycle. Now and then a stray selection (unknown codes
	// included) lands between runs. Tick requests carry a random pattern_code,
	// which the block must ignore. The last run is cut short so that exactly
	// the target number of requests is queued.
	task automatic queue_pattern_runs(input int target);
		int made;
		int run;
		made = 0;
		while (made < target) begin
			if ($urandom_range(0, 9) == 0) begin
				queue_request(CMD_SELECT, 3'($urandom_range(0, 7)), 1'b0);
				made++;
			end else begin
				queue_request(CMD_SELECT, 3'($urandom_range(0, 4)), $urandom_range(0, 149) == 0);
				made++;
				run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
				if (run > target - made)
					run = target - made;
				repeat (run) begin
					queue_request(CMD_TICK, 3'($urandom_range(0, 7)), $urandom_range(0, 149) == 0);
					made++;
				end
			end
		end
	endtask

	// Returns once nothing is queued, offered or owed, then keeps waiting so the
	// block's two pipeline registers are surely empty before a register write.
	task automatic wait_for_drain();
		while (queued_requests.size() != 0 || s_axis_tvalid || owed_views.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register writes only happen while the block is idle, so the predictor's
	// copy can be updated at once.
	task automatic write_side_mask(input logic [0:0] index, input logic [7:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (index == REG_LEFT_MASK)
			model_left = value;
		else
			model_right = value;
	endtask

	// Sender: offers the oldest queued request at a falling edge once the
	// previous one has been taken, its drawn gap has run out and, for a held request, no result is owed.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || req_taken) begin
			if (send_wait > 0) begin
				s_axis_tvalid <= 1'b0;
				send_wait--;
			end else if (queued_requests.size() != 0 &&
					!(queued_requests[0].hold_for_drain && owed_views.size() != 0)) begin
				next_request = queued_requests.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= next_request.command;
				s_axis_tdata <= {5'b00000, next_request.code};
				send_wait = draw_wait(sender_idles);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: after each result it takes, it draws a stall before the next.
	always @(negedge clk) begin
		if (res_taken)
			stall_wait = draw_wait(receiver_idles);
		if (!arst_n || stall_wait > 0) begin
			m_axis_tready <= 1'b0;
			if (stall_wait > 0)
				stall_wait--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Monitor: at each rising edge, checks a taken result against the oldest
	// owed view, then predicts the view for a taken request. Results trail
	// their requests, so checking first never pops the view just pushed.
	always @(posedge clk) begin
		req_taken = arst_n && s_axis_tvalid && s_axis_tready;
		res_taken = arst_n && m_axis_tvalid && m_axis_tready;
		if (res_taken) begin
			if (owed_views.size() == 0) begin
				report_mismatch("unrequested result, brightness", m_axis_tdata[7:0], -1);
			end else begin
				owed = owed_views.pop_front();
				if (m_axis_tdata[7:0] !== owed.brightness)
					report_mismatch("brightness", m_axis_tdata[7:0], owed.brightness);
				if (m_axis_tdata[15:8] !== owed.shine)
					report_mismatch("shine_mask", m_axis_tdata[15:8], owed.shine);
				if (m_axis_tuser !== owed.refresh)
					report_mismatch("refresh", m_axis_tuser, owed.refresh);
				if (m_axis_tdata[23:16] !== owed.phase)
					report_mismatch("phase", m_axis_tdata[23:16], owed.phase);
			end
		end
		if (req_taken)
			owed_views.push_back(advance_pattern(s_axis_tuser, s_axis_tdata[2:0]));
		if (!arst_n || req_taken || res_taken)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[%0t] no transfer for %0d cycles", $realtime, QUIET_LIMIT);
			$display("tb_led_pattern_tick_generator: done, errors");
			$finish;
		end
	end

	// Side mask settings per phase; the first phase keeps the reset values.
	logic [7:0] left_plan[7];
	logic [7:0] right_plan[7];

	initial begin
		left_plan = '{8'd15, 8'h00, 8'hFF, 8'h00, 8'hA5, 8'h00, 8'hFF};
		right_plan = '{8'd240, 8'hFF, 8'h00, 8'h00, 8'h5A, 8'h00, 8'hFF};
		left_plan[3] = 8'($urandom_range(0, 255));
		right_plan[3] = 8'($urandom_range(0, 255));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. The first tick under solid must refresh once because a
		// change is pending out of reset; then every pattern is selected, a
		// repeated selection and the unknown codes must change nothing, and a
		// selection result must show a restarted, fully lit strip.
		queue_request(CMD_TICK, PAT_SOLID, 1'b0);
		queue_request(CMD_TICK, 3'd7, 1'b0);
		queue_request(CMD_SELECT, PAT_SOLID, 1'b0);
		queue_request(CMD_SELECT, PAT_FLASH, 1'b0);
		repeat (5) queue_request(CMD_TICK, PAT_SOLID, 1'b0);
		queue_request(CMD_SELECT, PAT_FLASH, 1'b0);
		queue_request(CMD_SELECT, 3'd5, 1'b0);
		queue_request(CMD_SELECT, 3'd6, 1'b0);
		queue_request(CMD_SELECT, 3'd7, 1'b0);
		queue_request(CMD_SELECT, PAT_BEACON, 1'b0);
		queue_request(CMD_TICK, PAT_SOLID, 1'b0);
		queue_request(CMD_TICK, PAT_SOLID, 1'b0);
		// The sender holds this selection back until the block has caught up.
		queue_request(CMD_SELECT, PAT_BREATHE, 1'b1);
		queue_request(CMD_TICK, PAT_SOLID, 1'b0);
		queue_request(CMD_TICK, PAT_SOLID, 1'b0);
		queue_request(CMD_SELECT, PAT_ALTERNATE, 1'b0);
		queue_request(CMD_TICK, PAT_SOLID, 1'b0);
		queue_request(CMD_SELECT, PAT_SOLID, 1'b0);
		queue_request(CMD_TICK, PAT_SOLID, 1'b0);
		wait_for_drain();

		// Random phases, each under its own side masks and idling mix: the
		// first idles on both sides, the second not at all.
		for (int phase_no = 0; phase_no < 7; phase_no++) begin
			if (phase_no > 0) begin
				write_side_mask(REG_LEFT_MASK, left_plan[phase_no]);
				write_side_mask(REG_RIGHT_MASK, right_plan[phase_no]);
			end
			sender_idles = (phase_no == 0) ? 1'b1 : (phase_no == 1) ? 1'b0 : 1'($urandom_range(0, 1));
			receiver_idles = (phase_no == 0) ? 1'b1 : (phase_no == 1) ? 1'b0 : 1'($urandom_range(0, 1));
			queue_pattern_runs(175);
			wait_for_drain();
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_led_pattern_tick_generator: done, clean");
		else
			$display("tb_led_pattern_tick_generator: done, errors");
		$finish;
	end

endmodule
